// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the conversion block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication under a clock, disabled while reset is active
`define D2B_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("conversion check failed");

// Condition that must hold at every clock edge out of reset
`define D2B_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("conversion check failed");

`endif

// ===== hw/rtl/d2b64_pkg.sv =====
`default_nettype none
package d2b64_pkg;

  localparam int SIG_W    = 64;
  localparam int EXP10_W  = 10;
  localparam int BEXP_W   = 13;
  localparam int LZ_W     = 6;
  localparam int MANT_W   = 53;
  localparam int PIPE_LAT = 5;
  localparam int ROM_BIG_W = 1024;

  localparam logic [17:0] SCALE_MUL  = 18'd217706;
  localparam logic [8:0]  LOW_MASK   = 9'h1FF;
  localparam logic [10:0] EXP_INF    = 11'h7FF;
  localparam logic [63:0] FRAC_MASK  = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGN_MASK  = 64'h8000_0000_0000_0000;

  typedef logic [127:0] rom_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/decimal_to_binary64_fast_convert.sv =====
`default_nettype none
// Decimal to binary64 converter, fast path.
// Input word: significand_i * 10^exponent_ten_i with sign negative_i, taken
// at a rising edge where start_i is high and busy_o is low. busy_o stays low:
// a new word may be taken every cycle.
// Result word: done_o is high for exactly one cycle with ok_o and
// result_bits_o; result_bits_o holds the correctly rounded binary64 pattern
// when ok_o is 1 and zero when ok_o is 0 (defer to a slower path).
// A zero significand returns a signed zero with ok_o = 1.
// Throughput one word per cycle. Stages: normalize and power-of-ten ROM
// read, 32x32 partial products, 128-bit product sums, boundary refinement,
// round and pack.
// The ROM is a constant table built at elaboration, read once per cycle
// with registered data; no clearing pass is needed after reset.
// Reset clears all stage valid bits; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module decimal_to_binary64_fast_convert #(
  parameter int TABLE_MIN_EXP = -348,
  parameter int TABLE_MAX_EXP = 347
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [d2b64_pkg::SIG_W-1:0]   significand_i,
  input  wire logic [d2b64_pkg::EXP10_W-1:0] exponent_ten_i,
  input  wire logic                          negative_i,
  output logic                               done_o,
  output logic                               ok_o,
  output logic [d2b64_pkg::SIG_W-1:0]        result_bits_o
);
  import d2b64_pkg::*;

  localparam int ROM_SIZE = TABLE_MAX_EXP - TABLE_MIN_EXP + 1;
  localparam int IDX_W    = $clog2(ROM_SIZE);
  localparam int MAX_K    = (-TABLE_MIN_EXP > TABLE_MAX_EXP) ? -TABLE_MIN_EXP : TABLE_MAX_EXP;

  typedef rom_word_t rom_arr_t [ROM_SIZE];

  function automatic int bit_len(logic [ROM_BIG_W-1:0] v);
    int n;
    n = 0;
    for (int i = 0; i < ROM_BIG_W; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic rom_word_t top128(logic [ROM_BIG_W-1:0] v);
    int n;
    logic [ROM_BIG_W-1:0] t;
    n = bit_len(v);
    if (n >= 128) t = v >> (n - 128);
    else t = v << (128 - n);
    return t[127:0];
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    logic [ROM_BIG_W-1:0] five, rem, quo;
    int z, b;
    r = '{default: '0};
    five = ROM_BIG_W'(1);
    for (int k = 0; k <= MAX_K; k++) begin
      if (k <= TABLE_MAX_EXP) r[k - TABLE_MIN_EXP] = top128(five);
      if (k >= 1 && -k >= TABLE_MIN_EXP) begin
        z = bit_len(five);
        b = (k <= 27) ? z + 127 : 2 * z + 128;
        rem = '0;
        quo = '0;
        for (int i = b; i >= 0; i--) begin
          rem = {rem[ROM_BIG_W-2:0], (i == b)};
          if (rem >= five) begin
            rem = rem - five;
            if (i < ROM_BIG_W) quo[i] = 1'b1;
          end
        end
        quo = quo + ROM_BIG_W'(1);
        r[-k - TABLE_MIN_EXP] = top128(quo);
      end
      five = (five << 2) + five;
    end
    return r;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  // stage 1: normalize, exponent estimate, ROM read
  logic                    v1_q;
  logic                    zero1_q, rng1_q, neg1_q;
  logic [SIG_W-1:0]        sig1_q;
  logic signed [BEXP_W-1:0] bexp1_q;
  rom_word_t               rom1_q;

  logic [LZ_W-1:0]         lz_d;
  logic                    found_d;
  logic signed [EXP10_W-1:0] e_s;
  logic                    in_rng_d;
  logic signed [11:0]      e_off_d;
  logic [IDX_W-1:0]        idx_d;
  logic signed [28:0]      scaled_full_d;
  logic signed [BEXP_W-1:0] bexp_d;

  assign e_s = $signed(exponent_ten_i);
  assign in_rng_d = (e_s >= TABLE_MIN_EXP) && (e_s <= TABLE_MAX_EXP);
  assign e_off_d = 12'(e_s) - 12'(TABLE_MIN_EXP);
  assign idx_d = in_rng_d ? IDX_W'(e_off_d) : '0;
  assign scaled_full_d = 29'(e_s) * $signed({11'd0, SCALE_MUL});
  assign bexp_d = BEXP_W'(scaled_full_d >>> 16) + BEXP_W'(1087) - BEXP_W'(lz_d);

  always_comb begin
    lz_d = '0;
    found_d = 1'b0;
    for (int i = SIG_W - 1; i >= 0; i--) begin
      if (!found_d && significand_i[i]) begin
        lz_d = LZ_W'(SIG_W - 1 - i);
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero1_q <= (significand_i == '0);
    rng1_q  <= in_rng_d;
    neg1_q  <= negative_i;
    sig1_q  <= significand_i << lz_d;
    bexp1_q <= bexp_d;
    rom1_q  <= ROM[idx_d];
  end

  // stage 2: partial products
  logic                     v2_q, zero2_q, rng2_q, neg2_q;
  logic [SIG_W-1:0]         sig2_q;
  logic signed [BEXP_W-1:0] bexp2_q;
  logic [63:0]              ph_q [4];
  logic [63:0]              pl_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zero2_q <= zero1_q;
    rng2_q  <= rng1_q;
    neg2_q  <= neg1_q;
    sig2_q  <= sig1_q;
    bexp2_q <= bexp1_q;
    ph_q[0] <= sig1_q[31:0]  * rom1_q[95:64];
    ph_q[1] <= sig1_q[31:0]  * rom1_q[127:96];
    ph_q[2] <= sig1_q[63:32] * rom1_q[95:64];
    ph_q[3] <= sig1_q[63:32] * rom1_q[127:96];
    pl_q[0] <= sig1_q[31:0]  * rom1_q[31:0];
    pl_q[1] <= sig1_q[31:0]  * rom1_q[63:32];
    pl_q[2] <= sig1_q[63:32] * rom1_q[31:0];
    pl_q[3] <= sig1_q[63:32] * rom1_q[63:32];
  end

  // stage 3: full products
  logic                     v3_q, zero3_q, rng3_q, neg3_q;
  logic [SIG_W-1:0]         sig3_q;
  logic signed [BEXP_W-1:0] bexp3_q;
  logic [127:0]             prod_hi3_q, prod_lo3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zero3_q <= zero2_q;
    rng3_q  <= rng2_q;
    neg3_q  <= neg2_q;
    sig3_q  <= sig2_q;
    bexp3_q <= bexp2_q;
    prod_hi3_q <= {ph_q[3], 64'd0} + {32'd0, ph_q[1], 32'd0}
                + {32'd0, ph_q[2], 32'd0} + {64'd0, ph_q[0]};
    prod_lo3_q <= {pl_q[3], 64'd0} + {32'd0, pl_q[1], 32'd0}
                + {32'd0, pl_q[2], 32'd0} + {64'd0, pl_q[0]};
  end

  // stage 4: refinement near a rounding boundary
  logic                     v4_q, zero4_q, neg4_q, fail4_q;
  logic signed [BEXP_W-1:0] bexp4_q;
  logic [63:0]              phi4_q, plo4_q;

  logic [63:0] phi_d, plo_d, shi_d, slo_d, nhi_d;
  logic [64:0] c1_d, nlo_d, c2_d;
  logic        near_d, unres_d;

  assign phi_d = prod_hi3_q[127:64];
  assign plo_d = prod_hi3_q[63:0];
  assign shi_d = prod_lo3_q[127:64];
  assign slo_d = prod_lo3_q[63:0];
  assign c1_d  = {1'b0, plo_d} + {1'b0, sig3_q};
  assign nlo_d = {1'b0, plo_d} + {1'b0, shi_d};
  assign c2_d  = {1'b0, slo_d} + {1'b0, sig3_q};
  assign nhi_d = phi_d + 64'(nlo_d[64]);
  assign near_d = (phi_d[8:0] == LOW_MASK) && c1_d[64];
  assign unres_d = near_d && (nhi_d[8:0] == LOW_MASK) && (&nlo_d[63:0]) && c2_d[64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zero4_q <= zero3_q;
    neg4_q  <= neg3_q;
    fail4_q <= !rng3_q || unres_d;
    bexp4_q <= bexp3_q;
    phi4_q  <= near_d ? nhi_d : phi_d;
    plo4_q  <= near_d ? nlo_d[63:0] : plo_d;
  end

  // stage 5: round and pack
  logic                     top_d, half_d, exp_bad_d, ok_d;
  logic [53:0]              mant_d, mant_r_d;
  logic [54:0]              mant_inc_d;
  logic [MANT_W-1:0]        mant_f_d;
  logic signed [BEXP_W-1:0] bexp_a_d, bexp_f_d;
  logic [63:0]              sign_d, bits_d;

  assign top_d    = phi4_q[63];
  assign mant_d   = top_d ? phi4_q[63:10] : phi4_q[62:9];
  assign bexp_a_d = bexp4_q - BEXP_W'(!top_d);
  assign half_d   = (plo4_q == '0) && (phi4_q[8:0] == '0) && (mant_d[1:0] == 2'b01);
  assign mant_inc_d = {1'b0, mant_d} + 55'(mant_d[0]);
  assign mant_r_d = mant_inc_d[54:1];
  assign mant_f_d = mant_r_d[53] ? mant_r_d[53:1] : mant_r_d[52:0];
  assign bexp_f_d = bexp_a_d + BEXP_W'(mant_r_d[53]);
  assign exp_bad_d = (bexp_f_d <= 0) || (bexp_f_d >= $signed({2'b00, EXP_INF}));
  assign ok_d   = zero4_q || !(fail4_q || half_d || exp_bad_d);
  assign sign_d = neg4_q ? SIGN_MASK : '0;

  always_comb begin
    if (zero4_q) begin
      bits_d = sign_d;
    end else if (ok_d) begin
      bits_d = {1'b0, bexp_f_d[10:0], 52'd0} | (64'(mant_f_d) & FRAC_MASK) | sign_d;
    end else begin
      bits_d = '0;
    end
  end

  logic        done_q, ok_q;
  logic [63:0] bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    bits_q <= bits_d;
  end

  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign result_bits_o = bits_q;

endmodule
`default_nettype wire

// ===== hw/rtl/d2b64_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module d2b64_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start_i,
  input wire logic                        busy_i,
  input wire logic                        done_i,
  input wire logic                        ok_i,
  input wire logic [d2b64_pkg::SIG_W-1:0] result_bits_i
);
  import d2b64_pkg::*;

  `D2B_ASSERT_IMPL(a_done_follows_start, clk_i, rst_ni, done_i,
                   $past(start_i && !busy_i, PIPE_LAT))
  `D2B_ASSERT_IMPL(a_defer_zero, clk_i, rst_ni, done_i && !ok_i, result_bits_i == '0)
  `D2B_ASSERT_IMPL(a_no_inf_nan, clk_i, rst_ni, done_i && ok_i,
                   result_bits_i[62:52] != EXP_INF)
  `D2B_ASSERT_IMPL(a_no_subnormal, clk_i, rst_ni,
                   done_i && ok_i && (result_bits_i[62:52] == '0),
                   result_bits_i[51:0] == '0)

endmodule

bind decimal_to_binary64_fast_convert d2b64_checker u_d2b64_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_i        (busy_o),
  .done_i        (done_o),
  .ok_i          (ok_o),
  .result_bits_i (result_bits_o)
);
`default_nettype wire

// ===== bench/convert_checker.sv =====
`timescale 1ns / 1ps
module convert_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [63:0] significand_i,
  input  wire logic [9:0]  exponent_ten_i,
  input  wire logic        negative_i,
  input  wire logic        done_i,
  input  wire logic        ok_i,
  input  wire logic [63:0] result_bits_i,
  output int               words_taken_o,
  output int               results_owed_o,
  output int               mismatches_o
);
  import d2b64_pkg::*;

  localparam int POW_MIN = -348;
  localparam int POW_MAX = 347;

  typedef struct packed {
    logic        ok;
    logic [63:0] bits;
  } conv_result_t;

  logic [63:0] pow10_hi [0:POW_MAX-POW_MIN];
  logic [63:0] pow10_lo [0:POW_MAX-POW_MIN];
  conv_result_t expected_q[$];

  function automatic int bit_len(logic [2047:0] x);
    for (int i = 2047; i >= 0; i--) begin
      if (x[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic logic [127:0] top_128(logic [2047:0] x);
    int n;
    logic [2047:0] w;
    n = bit_len(x);
    w = (n >= 128) ? x >> (n - 128) : x << (128 - n);
    return w[127:0];
  endfunction

  task automatic build_pow10_table();
    logic [2047:0] pow5;
    logic [2047:0] quo;
    logic [127:0] word;
    int z;
    int b;
    pow5 = 2048'd1;
    for (int k = 0; k <= 348; k++) begin
      if (k <= POW_MAX) begin
        word = top_128(pow5);
        pow10_hi[k - POW_MIN] = word[127:64];
        pow10_lo[k - POW_MIN] = word[63:0];
      end
      if (k >= 1 && -k >= POW_MIN) begin
        z = bit_len(pow5);
        b = (k <= 27) ? z + 127 : 2 * z + 128;
        quo = ((2048'd1 << b) / pow5) + 2048'd1;
        word = top_128(quo);
        pow10_hi[-k - POW_MIN] = word[127:64];
        pow10_lo[-k - POW_MIN] = word[63:0];
      end
      pow5 = pow5 * 5;
    end
  endtask

  function automatic conv_result_t convert(logic [63:0] sig_in, logic [9:0] e10, logic neg);
    conv_result_t r;
    int e;
    int lz;
    longint bexp;
    logic [63:0] sig;
    logic [63:0] phi;
    logic [63:0] plo;
    logic [63:0] mant;
    logic [127:0] p;
    logic [127:0] s;
    logic [64:0] t;
    logic [63:0] nhi;
    logic [63:0] nlo;
    logic top;
    r.ok = 1'b0;
    r.bits = '0;
    e = $signed(e10);
    if (sig_in == 0) begin
      r.ok = 1'b1;
      r.bits = neg ? SIGN_MASK : 64'd0;
      return r;
    end
    if (e < POW_MIN || e > POW_MAX) return r;
    sig = sig_in;
    lz = 0;
    while (!sig[63]) begin
      sig = sig << 1;
      lz++;
    end
    bexp = ((longint'(217706) * longint'(e)) >>> 16) + 64 + 1023 - lz;
    p = {64'd0, sig} * {64'd0, pow10_hi[e - POW_MIN]};
    phi = p[127:64];
    plo = p[63:0];
    t = {1'b0, plo} + {1'b0, sig};
    if (phi[8:0] == 9'h1FF && t[64]) begin
      s = {64'd0, sig} * {64'd0, pow10_lo[e - POW_MIN]};
      t = {1'b0, plo} + {1'b0, s[127:64]};
      nlo = t[63:0];
      nhi = phi + t[64];
      t = {1'b0, s[63:0]} + {1'b0, sig};
      if (nhi[8:0] == 9'h1FF && nlo == '1 && t[64]) return r;
      phi = nhi;
      plo = nlo;
    end
    top = phi[63];
    mant = phi >> (top + 9);
    bexp = bexp - (top ? 0 : 1);
    if (plo == 0 && phi[8:0] == 0 && mant[1:0] == 2'b01) return r;
    mant = mant + mant[0];
    mant = mant >> 1;
    if ((mant >> 53) != 0) begin
      mant = mant >> 1;
      bexp = bexp + 1;
    end
    if (bexp <= 0 || bexp >= 2047) return r;
    r.ok = 1'b1;
    r.bits = (64'(bexp) << 52) | (mant & FRAC_MASK) | (neg ? SIGN_MASK : 64'd0);
    return r;
  endfunction

  initial begin
    words_taken_o = 0;
    results_owed_o = 0;
    mismatches_o = 0;
    build_pow10_table();
  end

  always @(posedge clk_i) begin
    conv_result_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("unexpected result word ok=%b bits=%h", ok_i, result_bits_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.ok !== ok_i || want.bits !== result_bits_i) begin
            if (mismatches_o < 10)
              $display("mismatch: expected ok=%b bits=%h, got ok=%b bits=%h",
                       want.ok, want.bits, ok_i, result_bits_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(convert(significand_i, exponent_ten_i, negative_i));
        words_taken_o <= words_taken_o + 1;
      end
      results_owed_o <= expected_q.size();
    end
  end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [63:0] significand_i = '0;
  logic [9:0]  exponent_ten_i = '0;
  logic        negative_i = 1'b0;
  logic        done_o;
  logic        ok_o;
  logic [63:0] result_bits_o;
  int          words_taken;
  int          results_owed;
  int          mismatches;
  int          stall_cycles = 0;

  localparam int STALL_LIMIT = 2000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  decimal_to_binary64_fast_convert dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .significand_i, .exponent_ten_i,
    .negative_i, .done_o, .ok_o, .result_bits_o
  );

  convert_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .significand_i, .exponent_ten_i,
    .negative_i, .done_i(done_o), .ok_i(ok_o), .result_bits_i(result_bits_o),
    .words_taken_o(words_taken), .results_owed_o(results_owed),
    .mismatches_o(mismatches)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("decimal_to_binary64_fast_convert verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_word(logic [63:0] sig, logic [9:0] e10, logic neg, bit may_idle);
    int target;
    if (may_idle) begin
      while ($urandom_range(0, 99) < 22) begin
        start_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    significand_i  <= sig;
    exponent_ten_i <= e10;
    negative_i     <= neg;
    start_i        <= 1'b1;
    target = words_taken + 1;
    do @(negedge clk_i); while (words_taken < target);
  endtask

  function automatic logic [63:0] random_significand();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} % 64'd10000000000000000000;
      2: return 64'($urandom_range(1, 999999));
      3: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {11'd0, 1'b1, $urandom_range(0, 1) ? 52'd0 : {20'd0, $urandom}} + 1;
    endcase
  endfunction

  function automatic logic [9:0] random_exponent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 10'($signed($urandom_range(0, 50)) - 25);
    if (r < 88) return 10'($signed($urandom_range(0, 695)) - 348);
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(64'd0, 10'd0, 1'b0, 0);
    send_word(64'd0, 10'd5, 1'b1, 0);
    send_word('1, 10'd0, 1'b0, 0);
    send_word('1, 10'd0, 1'b1, 0);
    send_word(64'd1, 10'd0, 1'b0, 0);
    send_word(64'd1, -10'sd348, 1'b0, 0);
    send_word(64'd1, 10'sd347, 1'b0, 0);
    send_word(64'd1, -10'sd349, 1'b0, 0);
    send_word(64'd1, 10'sd348, 1'b1, 0);
    send_word(64'd7, -10'sd512, 1'b0, 0);
    send_word(64'd7, 10'sd511, 1'b0, 0);
    send_word(64'd9007199254740993, 10'd0, 1'b0, 0);
    send_word(64'd9007199254740995, 10'd0, 1'b1, 0);
    send_word(64'd5, -10'sd324, 1'b0, 0);
    send_word(64'd1, -10'sd320, 1'b0, 0);
    send_word(64'd22250738585072014, -10'sd324, 1'b0, 0);
    send_word(64'd17976931348623157, 10'sd292, 1'b0, 0);
    send_word(64'd9, 10'sd308, 1'b0, 0);
    send_word(64'd123456789, -10'sd5, 1'b1, 0);
    send_word(64'd9999999999999999999, 10'sd22, 1'b0, 0);
    send_word(64'h8000_0000_0000_0000, -10'sd1, 1'b0, 0);
    send_word(64'd3, -10'sd1, 1'b0, 0);

    for (int i = 0; i < 1900; i++) begin
      if (i == 1000) begin
        start_i <= 1'b0;
        @(negedge clk_i);
        while (results_owed != 0) @(negedge clk_i);
      end
      send_word(random_significand(), random_exponent(), 1'($urandom),
                !(i >= 600 && i < 900));
    end
    start_i <= 1'b0;

    while (results_owed != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0)
      $display("decimal_to_binary64_fast_convert verification clean");
    else
      $display("decimal_to_binary64_fast_convert verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/d2b64_pkg.sv
hw/rtl/decimal_to_binary64_fast_convert.sv
hw/rtl/d2b64_checker.sv
bench/convert_checker.sv
bench/testbench.sv
